### hdl/assert_macros.svh
// Assertion macros shared by the rotor ring force RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define ASSERT_DLY(lbl, clk, rst, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

### hdl/rr_pkg.sv
// Shared types, constants and sine-cell control table for the rotor ring force block.
// No dependencies; used by rr_sine_cell, rr_sine_chain and the top level.
package rr_pkg;

  localparam int SITE_W     = 12;
  localparam int PHASE_W    = 16;
  localparam int LANE_W     = 16;
  localparam int SINE_W     = 17;
  localparam int SINE_CELLS = 4;
  localparam int CELL_IDX_W = 2;
  // fold stage, the cells, sign stage
  localparam int CHAIN_LAT  = SINE_CELLS + 2;

  localparam logic [LANE_W-1:0] SIN_C1 = 16'd25736;
  localparam logic [LANE_W-1:0] SIN_C3 = 16'd10512;
  localparam logic [LANE_W-1:0] SIN_C5 = 16'd1160;

  // operand A source
  localparam logic A_X  = 1'b0;
  localparam logic A_X2 = 1'b1;
  // operand B source
  localparam logic [1:0] B_X     = 2'd0;
  localparam logic [1:0] B_T     = 2'd1;
  localparam logic [1:0] B_CONST = 2'd2;
  // result destination
  localparam logic D_X2 = 1'b0;
  localparam logic D_T  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic              which;
    logic              neg;
    logic [LANE_W-1:0] x;
    logic [LANE_W-1:0] x2;
    logic [LANE_W-1:0] t;
  } sine_lane_t;

  typedef struct packed {
    logic              a_sel;
    logic [1:0]        b_sel;
    logic [LANE_W-1:0] konst;
    logic [LANE_W-1:0] bias;
    logic              sub;
    logic              dest;
  } cell_ctl_t;

  typedef struct packed {
    logic               valid;
    logic               which;
    logic [PHASE_W-1:0] phase;
  } sine_req_t;

  typedef struct packed {
    logic                     valid;
    logic                     which;
    logic signed [SINE_W-1:0] value;
  } sine_rsp_t;

  // Polynomial steps: x2 = x*x, t = C3 - x2*C5, t = C1 - x2*t, y = x*t (all >> 14)
  function automatic cell_ctl_t cell_ctl(input logic [CELL_IDX_W-1:0] idx);
    cell_ctl_t c;
    c = '0;
    unique case (idx)
      2'd0: begin
        c.a_sel = A_X;  c.b_sel = B_X;     c.sub = 1'b0; c.dest = D_X2;
      end
      2'd1: begin
        c.a_sel = A_X2; c.b_sel = B_CONST; c.konst = SIN_C5;
        c.bias = SIN_C3; c.sub = 1'b1; c.dest = D_T;
      end
      2'd2: begin
        c.a_sel = A_X2; c.b_sel = B_T; c.bias = SIN_C1; c.sub = 1'b1; c.dest = D_T;
      end
      default: begin
        c.a_sel = A_X;  c.b_sel = B_T; c.sub = 1'b0; c.dest = D_T;
      end
    endcase
    return c;
  endfunction

endpackage

### hdl/rr_sine_cell.sv
// One multiply-shift-subtract cell of the sine polynomial chain.
// Depends on rr_pkg for the lane and control types.
module rr_sine_cell (
  input  logic               clk,
  input  logic               rst,
  input  rr_pkg::cell_ctl_t  ctl,
  input  rr_pkg::sine_lane_t lane_in,
  output rr_pkg::sine_lane_t lane_out
);

  logic [rr_pkg::LANE_W-1:0]   op_a;
  logic [rr_pkg::LANE_W-1:0]   op_b;
  logic [2*rr_pkg::LANE_W-1:0] prod;
  logic [rr_pkg::LANE_W-1:0]   scaled;
  logic [rr_pkg::LANE_W-1:0]   res;
  rr_pkg::sine_lane_t          lane_next;

  always_comb begin
    op_a = (ctl.a_sel == rr_pkg::A_X2) ? lane_in.x2 : lane_in.x;
    unique case (ctl.b_sel)
      rr_pkg::B_X:     op_b = lane_in.x;
      rr_pkg::B_T:     op_b = lane_in.t;
      rr_pkg::B_CONST: op_b = ctl.konst;
      default:         op_b = ctl.konst;
    endcase
    prod   = op_a * op_b;
    // every intermediate stays below 2^16, so the upper product bits are zero
    scaled = prod[29:14];
    res    = ctl.sub ? (ctl.bias - scaled) : scaled;
    lane_next = lane_in;
    if (ctl.dest == rr_pkg::D_T) begin
      lane_next.t = res;
    end else begin
      lane_next.x2 = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out <= '0;
    end else begin
      lane_out <= lane_next;
    end
  end

endmodule

### hdl/rr_sine_chain.sv
// Pipelined fixed-point sine: phase fold, a row of polynomial cells, sign stage.
// Depends on rr_pkg, rr_sine_cell and assert_macros.svh.
`include "assert_macros.svh"

module rr_sine_chain (
  input  logic              clk,
  input  logic              rst,
  input  rr_pkg::sine_req_t req,
  output rr_pkg::sine_rsp_t rsp
);

  localparam int LAT = rr_pkg::CHAIN_LAT;

  rr_pkg::sine_lane_t lanes [rr_pkg::SINE_CELLS+1];
  rr_pkg::sine_lane_t fold_next;
  rr_pkg::sine_lane_t fold_q;
  logic signed [rr_pkg::PHASE_W+1:0] ph_ext;
  logic signed [rr_pkg::PHASE_W+1:0] folded;
  logic signed [rr_pkg::PHASE_W+1:0] mag;

  // fold the phase into -pi/2..pi/2 and split off the sign
  always_comb begin
    ph_ext = (rr_pkg::PHASE_W+2)'($signed(req.phase));
    priority if (ph_ext > 18'sd16384) begin
      folded = 18'sd32768 - ph_ext;
    end else if (ph_ext < -18'sd16384) begin
      folded = -18'sd32768 - ph_ext;
    end else begin
      folded = ph_ext;
    end
    mag = (folded < 0) ? -folded : folded;
    fold_next       = '0;
    fold_next.valid = req.valid;
    fold_next.which = req.which;
    fold_next.neg   = folded < 0;
    fold_next.x     = mag[rr_pkg::LANE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_q <= '0;
    end else begin
      fold_q <= fold_next;
    end
  end

  assign lanes[0] = fold_q;

  for (genvar i = 0; i < rr_pkg::SINE_CELLS; i++) begin : g_cell
    rr_sine_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (rr_pkg::cell_ctl(rr_pkg::CELL_IDX_W'(i))),
      .lane_in  (lanes[i]),
      .lane_out (lanes[i+1])
    );
  end

  logic signed [rr_pkg::SINE_W-1:0] mag_out;
  assign mag_out = $signed({1'b0, lanes[rr_pkg::SINE_CELLS].t});

  always_ff @(posedge clk) begin
    rsp.which <= lanes[rr_pkg::SINE_CELLS].which;
    rsp.value <= lanes[rr_pkg::SINE_CELLS].neg ? -mag_out : mag_out;
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= lanes[rr_pkg::SINE_CELLS].valid;
    end
  end

  `ASSERT_DLY(a_chain_latency, clk, rst, req.valid, LAT, rsp.valid, "sine result missing")
  `ASSERT_DLY(a_chain_tag, clk, rst, req.valid && req.which, LAT, rsp.which, "sine tag lost in chain")

endmodule

### hdl/rotor_ring_force_stream_top.sv
// Each accepted angle sends two sines through the 6-stage sine chain; its force beats are
// then formed and loaded one at a time, and the input stays stalled until all beats of the
// current angle have been loaded; a closing angle yields up to three forces.
// A stalled beat blocks the input only while further beats of the same angle remain.
// Reset (rst, synchronous): clears ring state and site count, coupling returns to 1.0.
// Top level of the rotor ring force stream; depends on rr_pkg, rr_sine_chain, assert_macros.svh.
`include "assert_macros.svh"

module rotor_ring_force_stream_top #(
  parameter int MAX_SITES  = 4096,
  parameter int ANGLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [ANGLE_BITS-1:0]    angle,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rr_pkg::SITE_W-1:0]       site,
  output logic signed [24:0]              force_value,
  output logic                            end_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [15:0]                     coupling
);

  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int SUM_W = rr_pkg::SINE_W + 1;
  localparam int PROD_W = SUM_W + 17;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ISSUE_D = 3'd1;
  localparam logic [2:0] S_ISSUE_W = 3'd2;
  localparam logic [2:0] S_WAIT    = 3'd3;
  localparam logic [2:0] S_SUM     = 3'd4;
  localparam logic [2:0] S_MUL     = 3'd5;
  localparam logic [2:0] S_LOAD    = 3'd6;

  localparam logic signed [PROD_W-9:0] FORCE_MAX = (PROD_W-8)'(16777215);
  localparam logic signed [PROD_W-9:0] FORCE_MIN = -(PROD_W-8)'(16777216);

  logic [2:0]                       state;
  logic [15:0]                      coupling_q;
  logic [CNT_W-1:0]                 cnt;
  logic [CNT_W-1:0]                 n_q;
  logic                             last_q;
  logic [ANGLE_BITS-1:0]            first_angle;
  logic [ANGLE_BITS-1:0]            cur_angle;
  logic [rr_pkg::PHASE_W-1:0]       phase_d;
  logic [rr_pkg::PHASE_W-1:0]       phase_w;
  logic signed [rr_pkg::SINE_W-1:0] prev_sine;
  logic signed [rr_pkg::SINE_W-1:0] first_sine;
  logic signed [rr_pkg::SINE_W-1:0] d_q;
  logic signed [rr_pkg::SINE_W-1:0] dw_q;
  logic [2:0]                       pend;
  logic signed [SUM_W-1:0]          slot_sum  [3];
  logic [rr_pkg::SITE_W-1:0]        slot_site [3];
  logic [2:0]                       slot_end;
  logic signed [PROD_W-1:0]         prod;
  logic [rr_pkg::SITE_W-1:0]        res_site;
  logic                             res_end;

  rr_pkg::sine_req_t req;
  rr_pkg::sine_rsp_t rsp;

  rr_sine_chain u_chain (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  logic accept;
  logic out_free;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // wrapped differences, scaled so that one full turn spans the 16-bit phase
  logic [ANGLE_BITS-1:0]                 diff_d;
  logic [ANGLE_BITS-1:0]                 diff_w;
  logic [ANGLE_BITS+rr_pkg::PHASE_W-1:0] ext_d;
  logic [ANGLE_BITS+rr_pkg::PHASE_W-1:0] ext_w;
  assign diff_d = $unsigned(angle) - cur_angle;
  assign diff_w = first_angle - $unsigned(angle);
  assign ext_d  = {diff_d, {rr_pkg::PHASE_W{1'b0}}};
  assign ext_w  = {diff_w, {rr_pkg::PHASE_W{1'b0}}};

  always_comb begin
    req.valid = (state == S_ISSUE_D) || (state == S_ISSUE_W);
    req.which = (state == S_ISSUE_W);
    req.phase = (state == S_ISSUE_W) ? phase_w : phase_d;
  end

  // site labels, saturated at MAX_SITES-1
  logic [CNT_W-1:0]                 cnt_cap;
  logic [CNT_W-1:0]                 n_dec;
  logic [CNT_W-1:0]                 n_sat;
  logic [CNT_W+rr_pkg::SITE_W-1:0]  ext_prev;
  logic [CNT_W+rr_pkg::SITE_W-1:0]  ext_cur;
  logic [rr_pkg::SITE_W-1:0]        lab_prev;
  logic [rr_pkg::SITE_W-1:0]        lab_cur;
  assign cnt_cap  = CNT_W'(MAX_SITES);
  assign n_dec    = n_q - CNT_W'(1);
  assign n_sat    = (n_q == cnt_cap) ? n_dec : n_q;
  assign ext_prev = {{rr_pkg::SITE_W{1'b0}}, n_dec};
  assign ext_cur  = {{rr_pkg::SITE_W{1'b0}}, n_sat};
  assign lab_prev = ext_prev[rr_pkg::SITE_W-1:0];
  assign lab_cur  = ext_cur[rr_pkg::SITE_W-1:0];

  logic                             n_zero;
  logic                             n_one;
  logic                             n_two_up;
  logic signed [rr_pkg::SINE_W-1:0] d_eff;
  logic signed [rr_pkg::SINE_W-1:0] fs_eff;
  logic [2:0]                       pend_new;
  assign n_zero   = (n_q == '0);
  assign n_one    = (n_q == CNT_W'(1));
  assign n_two_up = !n_zero && !n_one;
  assign d_eff    = n_zero ? '0 : d_q;
  assign fs_eff   = n_one ? d_q : first_sine;
  assign pend_new = {last_q && !n_zero, last_q, n_two_up};

  // lowest pending result goes first
  logic [1:0] sel;
  always_comb begin
    priority if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  logic signed [PROD_W-9:0] q_force;
  logic signed [24:0]       sat_force;
  assign q_force = prod[PROD_W-1:8];
  always_comb begin
    priority if (q_force > FORCE_MAX) begin
      sat_force = 25'(FORCE_MAX);
    end else if (q_force < FORCE_MIN) begin
      sat_force = 25'(FORCE_MIN);
    end else begin
      sat_force = 25'(q_force);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      coupling_q  <= 16'd256;
      cnt         <= '0;
      first_angle <= '0;
      cur_angle   <= '0;
      prev_sine   <= '0;
      first_sine  <= '0;
      pend        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        coupling_q <= coupling;
      end
      // in the load step the leaving beat is replaced below
      if (out_valid && !out_stall && state != S_LOAD) begin
        out_valid <= 1'b0;
      end
      if (rsp.valid && !rsp.which) begin
        d_q <= rsp.value;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n_q     <= cnt;
            last_q  <= last;
            phase_d <= ext_d[ANGLE_BITS+rr_pkg::PHASE_W-1 -: rr_pkg::PHASE_W];
            phase_w <= ext_w[ANGLE_BITS+rr_pkg::PHASE_W-1 -: rr_pkg::PHASE_W];
            if (last) begin
              first_angle <= '0;
              cur_angle   <= '0;
              cnt         <= '0;
            end else begin
              if (cnt == '0) begin
                first_angle <= $unsigned(angle);
              end
              cur_angle <= $unsigned(angle);
              if (cnt != cnt_cap) begin
                cnt <= cnt + CNT_W'(1);
              end
            end
            state <= S_ISSUE_D;
          end
        end
        S_ISSUE_D: state <= S_ISSUE_W;
        S_ISSUE_W: state <= S_WAIT;
        S_WAIT: begin
          if (rsp.valid && rsp.which) begin
            dw_q  <= rsp.value;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          slot_sum[0]  <= SUM_W'(prev_sine) - SUM_W'(d_eff);
          slot_site[0] <= lab_prev;
          slot_sum[1]  <= n_zero ? '0 : (SUM_W'(d_eff) - SUM_W'(dw_q));
          slot_site[1] <= n_zero ? '0 : lab_cur;
          slot_sum[2]  <= SUM_W'(dw_q) - SUM_W'(fs_eff);
          slot_site[2] <= '0;
          slot_end     <= {1'b1, n_zero, 1'b0};
          pend         <= pend_new;
          if (last_q) begin
            prev_sine  <= '0;
            first_sine <= '0;
          end else begin
            prev_sine <= d_eff;
            if (n_one) begin
              first_sine <= d_q;
            end
          end
          state <= (pend_new != 3'b000) ? S_MUL : S_IDLE;
        end
        S_MUL: begin
          prod      <= $signed({1'b0, coupling_q}) * slot_sum[sel];
          res_site  <= slot_site[sel];
          res_end   <= slot_end[sel];
          pend[sel] <= 1'b0;
          state     <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            site        <= res_site;
            force_value <= sat_force;
            end_of_run  <= res_end;
            state       <= (pend != 3'b000) ? S_MUL : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_sine_in_wait, clk, rst, rsp.valid, state == S_WAIT, "sine result outside wait")
  `ASSERT_NXT(a_accept_issue, clk, rst, accept, state == S_ISSUE_D, "accepted angle not issued")
  `ASSERT_IMP(a_mul_pending, clk, rst, state == S_MUL, pend != 3'b000, "nothing pending")
  `ASSERT_IMP(a_end_site0, clk, rst, out_valid && end_of_run, site == '0, "closing beat not site 0")

endmodule

### tb/sv/tb_rotor_ring_force_stream_top.sv
// Self-checking testbench for rotor_ring_force_stream_top: runs of ring angles in,
// per-site force beats out, checked against a scoreboard that predicts every beat.
// Depends on rr_pkg and the RTL under hdl/.
module tb_rotor_ring_force_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SITES  = 4096;
  localparam int COUNT_CAP   = 65536;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 1200000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [rr_pkg::SITE_W-1:0] site;
    logic signed [24:0]        force_value;
    logic                      end_of_run;
  } force_beat_t;

  class ring_force_board;
    int unsigned coupling_q88;
    logic [15:0] first_ang;
    logic [15:0] cur_ang;
    int          prev_d;
    int          first_d;
    int unsigned count;
    force_beat_t pending_forces[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned angles_seen;
    int unsigned runs_seen;

    function new();
      coupling_q88 = 256;
      mismatches   = 0;
      checked      = 0;
      angles_seen  = 0;
      runs_seen    = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      first_ang = '0;
      cur_ang   = '0;
      prev_d    = 0;
      first_d   = 0;
      count     = 0;
    endfunction

    function int q14_sine(logic [15:0] phase);
      int a;
      longint x, x2, t, y;
      a = int'($signed(phase));
      if (a > 16384) a = 32768 - a;
      else if (a < -16384) a = -32768 - a;
      x  = (a < 0) ? -a : a;
      x2 = (x * x) >> 14;
      t  = 10512 - ((x2 * 1160) >> 14);
      t  = 25736 - ((x2 * t) >> 14);
      y  = (x * t) >> 14;
      return (a < 0) ? -int'(y) : int'(y);
    endfunction

    // sine of (b - a), difference wrapped to one turn
    function int wrapped_sine(logic [15:0] b, logic [15:0] a);
      logic [15:0] d;
      d = b - a;
      return q14_sine(d);
    endfunction

    function logic signed [24:0] scaled_force(int ssum);
      longint p, q;
      p = longint'(coupling_q88) * longint'(ssum);
      q = p >>> 8;
      if (q > 64'sd16777215) q = 64'sd16777215;
      if (q < -64'sd16777216) q = -64'sd16777216;
      return q[24:0];
    endfunction

    function logic [rr_pkg::SITE_W-1:0] site_label(int unsigned n);
      int unsigned c;
      c = (n > RING_SITES - 1) ? RING_SITES - 1 : n;
      return c[rr_pkg::SITE_W-1:0];
    endfunction

    function void push(logic [rr_pkg::SITE_W-1:0] s, logic signed [24:0] f, logic e);
      force_beat_t b;
      b.site        = s;
      b.force_value = f;
      b.end_of_run  = e;
      pending_forces.push_back(b);
    endfunction

    function void note_angle(logic [15:0] x, logic is_last);
      int d, dw;
      d = 0;
      angles_seen++;
      if (count >= 1) d = wrapped_sine(x, cur_ang);
      if (count == 0) first_ang = x;
      else if (count == 1) first_d = d;
      else push(site_label(count - 1), scaled_force(prev_d - d), 1'b0);
      if (is_last) begin
        runs_seen++;
        if (count == 0) begin
          push('0, '0, 1'b1);
        end else begin
          dw = wrapped_sine(first_ang, x);
          push(site_label(count), scaled_force(d - dw), 1'b0);
          push('0, scaled_force(dw - first_d), 1'b1);
        end
        clear_ring();
        return;
      end
      cur_ang = x;
      prev_d  = d;
      if (count < COUNT_CAP) count++;
    endfunction

    function void fail_note(string what);
      mismatches++;
      if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
    endfunction

    function void check_force(logic [rr_pkg::SITE_W-1:0] s, logic signed [24:0] f, logic e);
      force_beat_t w;
      checked++;
      if (pending_forces.size() == 0) begin
        fail_note($sformatf("unexpected beat site=%0d force=%0d end=%0b", s, f, e));
        return;
      end
      w = pending_forces.pop_front();
      if (s !== w.site || f !== w.force_value || e !== w.end_of_run)
        fail_note($sformatf("site %0d/%0d force %0d/%0d end %0b/%0b (expected/actual)",
                            w.site, s, w.force_value, f, w.end_of_run, e));
    endfunction

    function int pending();
      return pending_forces.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [15:0]        angle;
  logic                      last;
  logic                      out_valid;
  logic                      out_stall;
  logic [rr_pkg::SITE_W-1:0] site;
  logic signed [24:0]        force_value;
  logic                      end_of_run;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [15:0]               coupling;

  ring_force_board sb;
  bit              calm;
  int unsigned     cycles;
  int unsigned     settings_used;

  rotor_ring_force_stream_top #(
    .MAX_SITES (RING_SITES),
    .ANGLE_BITS(16)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .angle      (angle),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .site       (site),
    .force_value(force_value),
    .end_of_run (end_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .coupling   (coupling)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 21);
    end
  end

  // sample between edges so the beat seen is the one taken at the next edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_force(site, force_value, end_of_run);
  end

  task automatic send_angle(input logic [15:0] a, input logic l);
    logic stalled;
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    angle    <= a;
    last     <= l;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sb.note_angle(a, l);
  endtask

  // drop valid, wait for every predicted beat, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_coupling(input logic [15:0] v);
    logic rdy;
    cfg_valid <= 1'b1;
    coupling  <= v;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    sb.coupling_q88 = v;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle(logic [15:0] prev);
    logic [15:0] jitter;
    jitter = 16'($urandom_range(0, 64)) - 16'd32;
    case ($urandom_range(0, 9))
      5, 6:    return prev + jitter;
      7:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      8:       return prev + (($urandom_range(0, 1) != 0) ? 16'h4000 : 16'hC000) + jitter;
      9:       return prev + 16'h8000 + jitter;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_run(input int len);
    logic [15:0] a;
    a = 16'($urandom());
    for (int i = 0; i < len; i++) begin
      a = pick_angle(a);
      send_angle(a, i == len - 1);
    end
  endtask

  // random runs until the budget is spent; runs are mostly short
  task automatic random_runs(input int budget, input int calm_from, input int calm_to);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      calm = (sent >= calm_from && sent < calm_to);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      send_run(len);
      sent += len;
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    sb            = new();
    calm          = 1'b0;
    settings_used = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    angle         = '0;
    last          = 1'b0;
    out_stall     = 1'b0;
    cfg_valid     = 1'b0;
    coupling      = 16'd256;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed runs at the reset coupling of 1.0
    send_angle(16'h0000, 1'b1);                 // one-site ring
    send_angle(16'h8000, 1'b1);
    send_angle(16'h7FFF, 1'b0);                 // two-site ring
    send_angle(16'h8000, 1'b1);
    send_angle(16'h0000, 1'b0);                 // quarter- and half-turn steps
    send_angle(16'h4000, 1'b0);
    send_angle(16'hC000, 1'b1);
    send_angle(16'h8000, 1'b0);                 // fold edges and wrap
    send_angle(16'h7FFF, 1'b0);
    send_angle(16'h0000, 1'b0);
    send_angle(16'h4001, 1'b0);
    send_angle(16'h0001, 1'b0);
    send_angle(16'hFFFF, 1'b1);
    send_angle(16'd100, 1'b0);
    send_angle(16'h2000, 1'b0);
    send_angle(16'h6000, 1'b0);
    send_angle(16'hA000, 1'b0);
    send_angle(16'hE000, 1'b1);
    for (int i = 0; i < 4; i++) send_angle(16'd12345, i == 3);  // flat ring
    settle();

    write_coupling(16'hFFFF);
    random_runs(110, 20, 90);
    write_coupling(16'h0000);
    random_runs(60, 0, 0);
    write_coupling(16'h0001);
    random_runs(60, 0, 0);
    write_coupling(16'($urandom_range(2, 65534)));
    random_runs(110, 0, 0);
    write_coupling(16'd256);
    random_runs(120, 0, 0);

    if (sb.pending() != 0) sb.fail_note($sformatf("%0d beats never arrived", sb.pending()));
    $display("covered %0d angles in %0d rings over %0d coupling writes (0 and 65535 among them)",
             sb.angles_seen, sb.runs_seen, settings_used);
    $display("%0d force beats checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### rotor_ring_force_stream_top.f
+incdir+hdl
hdl/rr_pkg.sv
hdl/rr_sine_cell.sv
hdl/rr_sine_chain.sv
hdl/rotor_ring_force_stream_top.sv
tb/sv/tb_rotor_ring_force_stream_top.sv
